// ===== hdl/box_average_downscaler_assert.svh =====
// Assertion macros for the box average downscaler
`ifndef BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define BAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BAD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BAD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bad_pkg.sv =====
// Shared types, constants and helpers for the box average downscaler
package bad_pkg;
   localparam int MAX_SRC_WIDTH = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int SCALE_FRAC_BITS = 8;
   localparam int MAX_SCALE = 16;
   localparam int ADDR_BITS = 16;
   localparam int ZOOM_LIMIT = MAX_SCALE << SCALE_FRAC_BITS;
   // window at most MAX_SCALE+1 wide per axis
   localparam int CNT_BITS = 10;
   localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
   // numerator sum*255 and denominator count*SMAX
   localparam int NUM_BITS = SUM_BITS + 8;
   localparam int DEN_BITS = CNT_BITS + SAMPLE_BITS;
   localparam int QUO_BITS = 8;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PAN_L  = 3'd2;
   localparam logic [2:0] REG_PAN_T  = 3'd3;
   localparam logic [2:0] REG_ZOOM   = 3'd4;

   typedef struct packed {
      logic load;      // write sample beat into memory
      logic start;     // latch render item, compute window
      logic step;      // visit next window pixel
      logic div_start; // begin dividing
      logic div_step;  // one quotient bit
      logic out_load;  // move quotients into the output register
   } cmd_type;

   typedef struct packed {
      logic win_last; // current pixel is the last in the window
      logic div_done; // last quotient bit taken
   } stat_type;
endpackage

// ===== hdl/bad_if.sv =====
// Valid/ready channel interfaces
interface bad_req_if import bad_pkg::*; ();
   logic valid;
   logic ready;
   logic op;
   logic [15:0] load_address;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;
   logic [11:0] screen_x;
   logic [11:0] screen_y;
   modport source (output valid, op, load_address, red_in, green_in, blue_in,
      screen_x, screen_y, input ready);
   modport sink (input valid, op, load_address, red_in, green_in, blue_in,
      screen_x, screen_y, output ready);
endinterface

interface bad_rsp_if ();
   logic valid;
   logic ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, red_out, green_out, blue_out, pixel_x, pixel_y,
      input ready);
   modport sink (input valid, red_out, green_out, blue_out, pixel_x, pixel_y,
      output ready);
endinterface

interface bad_csr_if ();
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/box_average_downscaler.sv =====
// Top level of the box average downscaler
// Box average downscaler. A load beat (op 0) writes one RGB sample triple into
// the 64K-entry source memory and returns no result. A render beat (op 1) maps
// the panned screen pixel to a source window of up to 16 by 16 pixels, walks it
// one pixel per cycle through the single memory read port, then divides the
// three channel sums by the pixel count with an eight-step restoring divider.
// The result waits in an output register until taken, and the next beat is
// taken once the result has moved into that register. Registers are written
// over the csr channel; the user must write them only while the block is idle,
// as the block itself does not enforce it. Pixels beyond the loaded image read
// as black; a never-written memory entry gives undefined samples.
module box_average_downscaler import bad_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   bad_req_if.sink   req,
   bad_rsp_if.source rsp,
   bad_csr_if.sink   csr
);
`include "box_average_downscaler_assert.svh"

   logic [8:0]  width_ff, height_ff;
   logic [15:0] pan_l_ff, pan_t_ff;
   logic [11:0] zoom_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [QUO_BITS-1:0] rq, gq, bq;
   logic [11:0] px, py;
   logic rsp_valid_ff;
   logic [7:0] r_ff, g_ff, b_ff;
   logic [11:0] x_ff, y_ff;

   // configuration: always ready, write on the beat
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         pan_l_ff <= '0;
         pan_t_ff <= '0;
         zoom_ff <= 12'd256;
      end else if (csr.valid) begin
         case (csr.index)
            REG_WIDTH:  width_ff <= csr.data[8:0];
            REG_HEIGHT: height_ff <= csr.data[8:0];
            REG_PAN_L:  pan_l_ff <= csr.data;
            REG_PAN_T:  pan_t_ff <= csr.data;
            REG_ZOOM:   zoom_ff <= csr.data[11:0];
            default: ;
         endcase
      end
   end

   bad_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_op(req.op),
      .req_ready(req.ready), .rsp_busy(rsp_valid_ff), .stat(stat), .cmd(cmd)
   );

   bad_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .load_address(req.load_address), .red_in(req.red_in),
      .green_in(req.green_in), .blue_in(req.blue_in),
      .screen_x(req.screen_x), .screen_y(req.screen_y),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .cfg_pan_l($signed(pan_l_ff)), .cfg_pan_t($signed(pan_t_ff)),
      .cfg_zoom(zoom_ff), .red_q(rq), .green_q(gq), .blue_q(bq),
      .pix_x(px), .pix_y(py)
   );

   // output register: hold the result until the sink takes the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         r_ff <= rq;
         g_ff <= gq;
         b_ff <= bq;
         x_ff <= px;
         y_ff <= py;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red_out = r_ff;
   assign rsp.green_out = g_ff;
   assign rsp.blue_out = b_ff;
   assign rsp.pixel_x = x_ff;
   assign rsp.pixel_y = y_ff;

   // a result is only loaded into a free output register
   `BAD_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff)
   // a held result stays until taken
   `BAD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff)
   // no new beat is taken while walking or dividing
   `BAD_ASSERT_IMPL(a_busy, clock, reset, cmd.step || cmd.div_step, !req.ready)
endmodule

// ===== hdl/bad_ctrl.sv =====
// Control state machine: sequences load, window walk, divide and result beat
module bad_ctrl import bad_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_op,
   output logic     req_ready,
   input  logic     rsp_busy,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WIN  = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_DRN  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [2:0] S_DST  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op) begin
                  cmd.start = 1'b1;
                  state_in = S_WIN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_WIN: state_in = S_WALK;
         S_WALK: begin
            cmd.step = 1'b1;
            if (stat.win_last) state_in = S_DRN;
         end
         S_DRN: begin
            // let the last memory read land in the sums
            state_in = S_DST;
         end
         S_DST: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== hdl/bad_dp.sv =====
// Datapath: source memory, window walker, accumulators and restoring divider
module bad_dp import bad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [ADDR_BITS-1:0]   load_address,
   input  logic [SAMPLE_BITS-1:0] red_in,
   input  logic [SAMPLE_BITS-1:0] green_in,
   input  logic [SAMPLE_BITS-1:0] blue_in,
   input  logic [11:0]            screen_x,
   input  logic [11:0]            screen_y,
   input  logic [8:0]             cfg_width,
   input  logic [8:0]             cfg_height,
   input  logic signed [15:0]     cfg_pan_l,
   input  logic signed [15:0]     cfg_pan_t,
   input  logic [11:0]            cfg_zoom,
   output logic [QUO_BITS-1:0]    red_q,
   output logic [QUO_BITS-1:0]    green_q,
   output logic [QUO_BITS-1:0]    blue_q,
   output logic [11:0]            pix_x,
   output logic [11:0]            pix_y
);
   localparam int CW = 30; // window coordinate width, signed
   localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};
   localparam int QC_BITS = $clog2(QUO_BITS + 1);

   logic [3*SAMPLE_BITS-1:0] mem [0:(1<<ADDR_BITS)-1];
   logic [3*SAMPLE_BITS-1:0] rd_ff;

   logic [11:0] sx_ff, sy_ff;
   logic [8:0]  w_ff, h_ff;
   logic signed [CW-1:0] x0_ff, x1_ff, y0_ff, y1_ff, xx_ff, yy_ff;
   logic signed [CW-1:0] x0_in, x1_in, y0_in, y1_in;
   logic rv_ff, in_img_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [SUM_BITS-1:0] sr_ff, sg_ff, sb_ff;
   logic [NUM_BITS-1:0] nr_ff, ng_ff, nb_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [QUO_BITS-1:0] qr_ff, qg_ff, qb_ff;
   logic [QC_BITS-1:0]  qc_ff;

   // windowing (one add and multiply per axis bound, registered)
   logic [8:0] w_sat, h_sat;
   logic [12:0] z_sat;
   logic signed [17:0] px, py;
   logic signed [CW-1:0] ax0, ax1, ay0, ay1;

   always_comb begin
      w_sat = (cfg_width > 9'(MAX_SRC_WIDTH)) ? 9'(MAX_SRC_WIDTH) : cfg_width;
      h_sat = (cfg_height > 9'(MAX_SRC_HEIGHT)) ? 9'(MAX_SRC_HEIGHT) : cfg_height;
      z_sat = ({1'b0, cfg_zoom} > 13'(ZOOM_LIMIT)) ? 13'(ZOOM_LIMIT) : {1'b0, cfg_zoom};
      px = $signed({6'd0, screen_x}) + 18'(cfg_pan_l);
      py = $signed({6'd0, screen_y}) + 18'(cfg_pan_t);
      ax0 = CW'(px * $signed({1'b0, z_sat})) >>> SCALE_FRAC_BITS;
      ax1 = CW'((px + 18'sd1) * $signed({1'b0, z_sat})) >>> SCALE_FRAC_BITS;
      ay0 = CW'(py * $signed({1'b0, z_sat})) >>> SCALE_FRAC_BITS;
      ay1 = CW'((py + 18'sd1) * $signed({1'b0, z_sat})) >>> SCALE_FRAC_BITS;
      x0_in = ax0;
      y0_in = ay0;
      x1_in = (ax1 <= ax0) ? ax0 + CW'(1) : ax1;
      y1_in = (ay1 <= ay0) ? ay0 + CW'(1) : ay1;
   end

   // memory: one write port, one registered read port
   logic in_img;
   logic [ADDR_BITS-1:0] raddr;
   logic [16:0] prod;
   logic [2:0] qbit;
   always_comb begin
      in_img = (xx_ff >= 0) && (yy_ff >= 0) && (xx_ff < $signed(CW'(w_ff)))
            && (yy_ff < $signed(CW'(h_ff)));
      prod = 17'(yy_ff[7:0]) * 17'(w_ff) + 17'(xx_ff[8:0]);
      raddr = prod[ADDR_BITS-1:0];
      stat.win_last = (xx_ff + CW'(1) >= x1_ff) && (yy_ff + CW'(1) >= y1_ff);
      stat.div_done = (qc_ff == QC_BITS'(QUO_BITS - 1));
      qbit = 3'(QUO_BITS - 1) - qc_ff[2:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) mem[load_address] <= {red_in, green_in, blue_in};
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.step;
      end
      in_img_ff <= in_img;
      if (cmd.start) begin
         sx_ff <= screen_x;
         sy_ff <= screen_y;
         w_ff <= w_sat;
         h_ff <= h_sat;
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         y0_ff <= y0_in;
         xx_ff <= x0_in;
         yy_ff <= y0_in;
         cnt_ff <= '0;
         sr_ff <= '0;
         sg_ff <= '0;
         sb_ff <= '0;
      end
      if (cmd.step) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
         if (xx_ff + CW'(1) >= x1_ff) begin
            xx_ff <= x0_ff;
            yy_ff <= yy_ff + CW'(1);
         end else begin
            xx_ff <= xx_ff + CW'(1);
         end
      end
      if (rv_ff && in_img_ff) begin
         sr_ff <= sr_ff + SUM_BITS'(rd_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
         sg_ff <= sg_ff + SUM_BITS'(rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);
         sb_ff <= sb_ff + SUM_BITS'(rd_ff[SAMPLE_BITS-1:0]);
      end
      if (cmd.div_start) begin
         nr_ff <= (NUM_BITS'(sr_ff) << 8) - NUM_BITS'(sr_ff);
         ng_ff <= (NUM_BITS'(sg_ff) << 8) - NUM_BITS'(sg_ff);
         nb_ff <= (NUM_BITS'(sb_ff) << 8) - NUM_BITS'(sb_ff);
         den_ff <= DEN_BITS'(cnt_ff) * DEN_BITS'(SMAX);
         qc_ff <= '0;
         qr_ff <= '0;
         qg_ff <= '0;
         qb_ff <= '0;
      end
      // restoring divide: quotient fits in eight bits, so trial den << bit
      if (cmd.div_step) begin
         qc_ff <= qc_ff + QC_BITS'(1);
         if (nr_ff >= (NUM_BITS'(den_ff) << qbit)) begin
            nr_ff <= nr_ff - (NUM_BITS'(den_ff) << qbit);
            qr_ff[qbit] <= 1'b1;
         end
         if (ng_ff >= (NUM_BITS'(den_ff) << qbit)) begin
            ng_ff <= ng_ff - (NUM_BITS'(den_ff) << qbit);
            qg_ff[qbit] <= 1'b1;
         end
         if (nb_ff >= (NUM_BITS'(den_ff) << qbit)) begin
            nb_ff <= nb_ff - (NUM_BITS'(den_ff) << qbit);
            qb_ff[qbit] <= 1'b1;
         end
      end
   end

   assign red_q = qr_ff;
   assign green_q = qg_ff;
   assign blue_q = qb_ff;
   assign pix_x = sx_ff;
   assign pix_y = sy_ff;
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the box average downscaler
`timescale 1ns / 1ps

module tb;
   import bad_pkg::*;

   typedef struct {
      bit        op;
      bit [15:0] addr;
      bit [15:0] r, g, b;
      bit [11:0] x, y;
   } beat_type;

   typedef struct {
      bit [7:0]  r, g, b;
      bit [11:0] x, y;
   } pixel_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bad_req_if req ();
   bad_rsp_if rsp ();
   bad_csr_if csr ();

   box_average_downscaler u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #5 clock = ~clock;

   // register shadow, updated on each accepted csr beat
   bit [8:0]         shd_width  = 9'd256;
   bit [8:0]         shd_height = 9'd256;
   bit signed [15:0] shd_pan_l  = '0;
   bit signed [15:0] shd_pan_t  = '0;
   bit [11:0]        shd_zoom   = 12'd256;

   // shadow of the source memory; entries are read only after being loaded
   bit [15:0] img_r [65536];
   bit [15:0] img_g [65536];
   bit [15:0] img_b [65536];

   beat_type  pending_beats[$];
   pixel_type expected_pixels[$];

   int unsigned sent_count   = 0;
   int unsigned accept_count = 0;
   int unsigned load_count   = 0;
   int unsigned render_count = 0;
   int unsigned csr_count    = 0;
   int unsigned error_count  = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   // Area-average one screen pixel from the shadow image.
   function automatic pixel_type average_window(bit [11:0] sx, bit [11:0] sy);
      pixel_type res;
      longint  w, h, z, px, py, x0, x1, y0, y1, cnt, den;
      longint  sr, sg, sb;
      int      a;
      w  = (shd_width  > MAX_SRC_WIDTH)  ? MAX_SRC_WIDTH  : shd_width;
      h  = (shd_height > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : shd_height;
      z  = (shd_zoom > ZOOM_LIMIT) ? ZOOM_LIMIT : shd_zoom;
      px = longint'(sx) + longint'(shd_pan_l);
      py = longint'(sy) + longint'(shd_pan_t);
      // arithmetic shift gives a true floor for negative products
      x0 = (px * z) >>> SCALE_FRAC_BITS;
      x1 = ((px + 1) * z) >>> SCALE_FRAC_BITS;
      y0 = (py * z) >>> SCALE_FRAC_BITS;
      y1 = ((py + 1) * z) >>> SCALE_FRAC_BITS;
      if (x1 <= x0) x1 = x0 + 1;
      if (y1 <= y0) y1 = y0 + 1;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (longint yy = y0; yy < y1; yy++) begin
         for (longint xx = x0; xx < x1; xx++) begin
            if (yy >= 0 && yy < h && xx >= 0 && xx < w) begin
               a = int'((yy * w + xx) & 16'hFFFF);
               sr += img_r[a];
               sg += img_g[a];
               sb += img_b[a];
            end
            cnt++;
         end
      end
      den   = cnt * ((1 << SAMPLE_BITS) - 1);
      res.r = 8'((sr * 255) / den);
      res.g = 8'((sg * 255) / den);
      res.b = 8'((sb * 255) / den);
      res.x = sx;
      res.y = sy;
      return res;
   endfunction

   // Driver: change inputs at the falling edge; hold a beat until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && accept_count != sent_count) begin
         // hold the current beat
      end else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         beat_type bt;
         bt = pending_beats.pop_front();
         req.valid        <= 1'b1;
         req.op           <= bt.op;
         req.load_address <= bt.addr;
         req.red_in       <= bt.r;
         req.green_in     <= bt.g;
         req.blue_in      <= bt.b;
         req.screen_x     <= bt.x;
         req.screen_y     <= bt.y;
         sent_count++;
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: sample at the rising edge, predict on accepted beats, check results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            accept_count++;
            if (req.op == 1'b0) begin
               img_r[req.load_address] = req.red_in;
               img_g[req.load_address] = req.green_in;
               img_b[req.load_address] = req.blue_in;
               load_count++;
            end else begin
               expected_pixels.push_back(average_window(req.screen_x, req.screen_y));
               render_count++;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result beat at x=%0d y=%0d", rsp.pixel_x, rsp.pixel_y);
               error_count++;
            end else begin
               pixel_type e;
               e = expected_pixels.pop_front();
               if (rsp.red_out !== e.r) begin
                  $error("red_out expected %0d got %0d", e.r, rsp.red_out);
                  error_count++;
               end
               if (rsp.green_out !== e.g) begin
                  $error("green_out expected %0d got %0d", e.g, rsp.green_out);
                  error_count++;
               end
               if (rsp.blue_out !== e.b) begin
                  $error("blue_out expected %0d got %0d", e.b, rsp.blue_out);
                  error_count++;
               end
               if (rsp.pixel_x !== e.x) begin
                  $error("pixel_x expected %0d got %0d", e.x, rsp.pixel_x);
                  error_count++;
               end
               if (rsp.pixel_y !== e.y) begin
                  $error("pixel_y expected %0d got %0d", e.y, rsp.pixel_y);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("box_average_downscaler verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Write one register; advance the shadow once the beat is taken.
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         REG_WIDTH:  shd_width  = val[8:0];
         REG_HEIGHT: shd_height = val[8:0];
         REG_PAN_L:  shd_pan_l  = val;
         REG_PAN_T:  shd_pan_t  = val;
         REG_ZOOM:   shd_zoom   = val[11:0];
         default: ;
      endcase
      csr_count++;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic beat_type load_beat(bit [15:0] addr);
      beat_type bt;
      bt.op = 1'b0;
      bt.addr = addr;
      bt.r = 16'($urandom);
      bt.g = 16'($urandom);
      bt.b = 16'($urandom);
      bt.x = 12'($urandom);
      bt.y = 12'($urandom);
      return bt;
   endfunction

   // Pick a screen coordinate whose window mostly lands on the image.
   function automatic bit [11:0] aim(int dim, int pan);
      int span, p;
      span = (dim * 256) / ((shd_zoom == 0) ? 1 : int'(shd_zoom)) + 3;
      p = int'($urandom_range(span + 2)) - 2 - pan;
      if ($urandom_range(3) == 0 || p < 0 || p > 4095)
         return 12'($urandom);
      return 12'(p);
   endfunction

   function automatic beat_type render_beat();
      beat_type bt;
      bt = load_beat(16'($urandom));
      bt.op = 1'b1;
      bt.x = aim((shd_width  > 256) ? 256 : shd_width,  shd_pan_l);
      bt.y = aim((shd_height > 256) ? 256 : shd_height, shd_pan_t);
      return bt;
   endfunction

   // Wait until every beat is sent and every result has arrived, then settle.
   task automatic drain();
      do @(posedge clock);
      while (pending_beats.size() != 0 || accept_count != sent_count
             || expected_pixels.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // One phase: program the registers, load the whole image, then render
   // mixed with reloads and stray loads.
   task automatic run_phase(int w, int h, int pl, int pt, int z, int renders, int mode);
      int area, eff_w, eff_h;
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
         default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      write_reg(REG_WIDTH,  16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      write_reg(REG_PAN_L,  16'(pl));
      write_reg(REG_PAN_T,  16'(pt));
      write_reg(REG_ZOOM,   16'(z));
      eff_w = (w > 256) ? 256 : w;
      eff_h = (h > 256) ? 256 : h;
      area = eff_w * eff_h;
      for (int i = 0; i < area; i++)
         pending_beats.push_back(load_beat(16'(i)));
      for (int i = 0; i < renders; i++) begin
         pending_beats.push_back(render_beat());
         if (area > 0 && $urandom_range(7) == 0)
            pending_beats.push_back(load_beat(16'($urandom_range(area - 1))));
         if ($urandom_range(15) == 0)
            pending_beats.push_back(load_beat(16'($urandom)));
      end
      drain();
   endtask

   initial begin
      beat_type bt;
      req.valid = 1'b0; req.op = 1'b0; req.load_address = '0;
      req.red_in = '0; req.green_in = '0; req.blue_in = '0;
      req.screen_x = '0; req.screen_y = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = REG_WIDTH; csr.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: 2x2 image of full-scale, zero and unit samples, then the corners,
      // negative panning, the far screen edge and a widened one-pixel window.
      write_reg(REG_WIDTH, 16'd2);
      write_reg(REG_HEIGHT, 16'd2);
      for (int i = 0; i < 4; i++) begin
         bt = load_beat(16'(i));
         bt.r = (i == 0) ? 16'hFFFF : 16'h0000;
         bt.g = (i == 1) ? 16'hFFFF : 16'h0000;
         bt.b = (i == 3) ? 16'hFFFF : 16'h0001;
         pending_beats.push_back(bt);
      end
      bt = load_beat(16'hFFFF);
      pending_beats.push_back(bt);
      for (int i = 0; i < 6; i++) begin
         bt = render_beat();
         bt.x = (i == 4) ? 12'hFFF : 12'(i % 2);
         bt.y = (i == 5) ? 12'hFFF : 12'(i / 2);
         pending_beats.push_back(bt);
      end
      drain();
      write_reg(REG_PAN_L, 16'hFFFF);
      write_reg(REG_PAN_T, 16'hFFFF);
      write_reg(REG_ZOOM, 16'd512);
      for (int i = 0; i < 6; i++) begin
         bt = render_beat();
         bt.x = 12'(i % 3);
         bt.y = 12'(i / 3);
         pending_beats.push_back(bt);
      end
      drain();
      write_reg(REG_ZOOM, 16'd64);
      for (int i = 0; i < 4; i++) begin
         bt = render_beat();
         bt.x = 12'(i + 3);
         bt.y = 12'(4 + i);
         pending_beats.push_back(bt);
      end
      drain();

      // Extremes first, then random small images and zooms.
      run_phase(511, 1, 0, 0, 4095, 40, 0);           // width saturates, largest zoom
      run_phase(0, 511, 3, -2, 256, 30, 1);           // zero width, height saturates
      run_phase(5, 0, 0, 0, 300, 30, 2);              // zero height
      run_phase(6, 5, 1, 1, 0, 40, 3);                // zero zoom
      run_phase(4, 4, -32768, 32767, 1, 30, 0);       // pan at both extremes, zoom one
      run_phase(3, 7, 32767, -32768, 4095, 30, 1);
      run_phase(8, 8, -3, 2, 4096 - 1, 40, 2);        // widest window
      for (int ph = 0; ph < 6; ph++) begin
         run_phase($urandom_range(1, 8), $urandom_range(1, 8),
                   int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                   ($urandom_range(3) == 0) ? $urandom_range(1, 4095)
                                             : $urandom_range(32, 600),
                   45, ph);
      end
      write_reg(REG_WIDTH, 16'd256);
      write_reg(REG_ZOOM, 16'd256);

      repeat (350) @(posedge clock);
      $display("covered %0d load beats, %0d render beats and %0d register writes",
               load_count, render_count, csr_count);
      $display("across saturating, empty, zero-zoom and extreme-pan settings");
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("box_average_downscaler verification clean");
      end else begin
         $display("box_average_downscaler verification failed");
      end
      $finish;
   end
endmodule

// ===== box_average_downscaler.f =====
+incdir+hdl
hdl/bad_pkg.sv
hdl/bad_if.sv
hdl/bad_ctrl.sv
hdl/bad_dp.sv
hdl/box_average_downscaler.sv
test/tb.sv
